FILE: hw/rtl/tsbt_pkg.sv
// Shared types and codes for the send-buffer tracker.
package tsbt_pkg;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_ACK     = 2'd2,
        OP_RESET   = 2'd3
    } op_e_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_OVERRUN  = 2'd2,
        STATUS_EXCESS   = 2'd3
    } status_e_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_ACK
    } fsm_e_t;

    typedef logic [4:0] held_t;

    typedef struct packed {
        op_e_t       operation;
        logic [31:0] byte_count;
    } in_t;

    typedef struct packed {
        status_e_t   status;
        logic        write_done;
        logic [31:0] written_bytes;
        logic [31:0] unsent_bytes;
        logic [31:0] unacked_bytes;
        held_t       entries_held;
    } out_t;

endpackage

FILE: hw/rtl/tcp_send_buffer_tracker.sv
// Send-buffer tracker: ring of buffer lengths with send and acknowledge pointers.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  s_      | in        | s_valid / s_ready | tsbt_pkg::in_t  (operation, bytes)
//  m_      | out       | m_valid / m_ready | tsbt_pkg::out_t (one result a beat)
//
// Push, advance and reset pass an accept step, which also issues the ring read, and
// an execute step that uses the registered read data.
// An acknowledge pops buffers while its bytes cover the head, each pop reading the
// new head from the ring; a buffer left partly acknowledged takes one more step.
// Reset needs no clearing pass: only entries pushed since the last reset are read.
// A result not taken holds the block before the next result is written; no beat is lost.
module tcp_send_buffer_tracker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tsbt_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tsbt_pkg::out_t  m_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    // Ring of buffer lengths, one registered read port and one write port.
    logic [31:0] ring [QUEUE_DEPTH];

    tsbt_pkg::fsm_e_t  state_reg, state_next;
    tsbt_pkg::op_e_t   op_reg, op_next;
    logic [31:0]       bytes_reg, bytes_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  send_entry_reg, send_entry_next;
    logic [31:0]       send_off_reg, send_off_next;
    logic [31:0]       ack_off_reg, ack_off_next;
    logic [31:0]       unsent_reg, unsent_next;
    logic [31:0]       unacked_reg, unacked_next;
    logic              m_valid_reg, m_valid_next;
    tsbt_pkg::out_t    m_data_reg, m_data_next;
    logic [31:0]       rd_data_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              out_free;
    logic              accept;
    logic [31:0]       len;
    logic [31:0]       rem_send;
    logic [31:0]       rem_ack;
    logic [31:0]       step_bytes;
    logic [31:0]       new_off;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] rel);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(rel);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == tsbt_pkg::FSM_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign len      = rd_data_reg;
    assign rem_send = len - send_off_reg;
    assign rem_ack  = len - ack_off_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        bytes_next      = bytes_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        send_entry_next = send_entry_reg;
        send_off_next   = send_off_reg;
        ack_off_next    = ack_off_reg;
        unsent_next     = unsent_reg;
        unacked_next    = unacked_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(head_reg, count_reg);
        step_bytes      = bytes_reg;
        new_off         = send_off_reg;

        unique case (state_reg)
            tsbt_pkg::FSM_IDLE: begin
                if (accept) begin
                    op_next    = s_data.operation;
                    bytes_next = s_data.byte_count;
                    rd_en      = 1'b1;
                    if (s_data.operation == tsbt_pkg::OP_ADVANCE) begin
                        rd_addr = slot_of(head_reg, send_entry_reg);
                    end
                    if (s_data.operation == tsbt_pkg::OP_ACK) begin
                        state_next = tsbt_pkg::FSM_ACK;
                    end else begin
                        state_next = tsbt_pkg::FSM_EXEC;
                    end
                end
            end

            tsbt_pkg::FSM_EXEC: begin
                if (out_free) begin
                    m_data_next.status        = tsbt_pkg::STATUS_OK;
                    m_data_next.write_done    = 1'b0;
                    m_data_next.written_bytes = '0;
                    unique case (op_reg)
                        tsbt_pkg::OP_PUSH: begin
                            if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                                m_data_next.status = tsbt_pkg::STATUS_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                unsent_next  = unsent_reg + bytes_reg;
                                unacked_next = unacked_reg + bytes_reg;
                            end
                        end
                        tsbt_pkg::OP_ADVANCE: begin
                            if (send_entry_reg >= count_reg) begin
                                if (bytes_reg != 32'd0) begin
                                    m_data_next.status = tsbt_pkg::STATUS_OVERRUN;
                                end
                            end else begin
                                if (bytes_reg > rem_send) begin
                                    step_bytes         = rem_send;
                                    m_data_next.status = tsbt_pkg::STATUS_OVERRUN;
                                end
                                new_off     = send_off_reg + step_bytes;
                                unsent_next = unsent_reg - step_bytes;
                                if (new_off == len) begin
                                    send_entry_next           = send_entry_reg + CNT_W'(1);
                                    send_off_next             = '0;
                                    m_data_next.write_done    = 1'b1;
                                    m_data_next.written_bytes = len;
                                end else begin
                                    send_off_next = new_off;
                                end
                            end
                        end
                        tsbt_pkg::OP_RESET: begin
                            if (send_off_reg != 32'd0) begin
                                m_data_next.write_done    = 1'b1;
                                m_data_next.written_bytes = send_off_reg;
                            end
                            head_next       = '0;
                            count_next      = '0;
                            send_entry_next = '0;
                            send_off_next   = '0;
                            ack_off_next    = '0;
                            unsent_next     = '0;
                            unacked_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                    m_data_next.unsent_bytes  = unsent_next;
                    m_data_next.unacked_bytes = unacked_next;
                    m_data_next.entries_held  = tsbt_pkg::held_t'(count_next);
                    m_valid_next = 1'b1;
                    state_next   = tsbt_pkg::FSM_IDLE;
                end
            end

            tsbt_pkg::FSM_ACK: begin
                priority if (bytes_reg == 32'd0 || count_reg == '0) begin
                    if (out_free) begin
                        m_data_next.status = (bytes_reg != 32'd0) ?
                            tsbt_pkg::STATUS_EXCESS : tsbt_pkg::STATUS_OK;
                        m_data_next.write_done    = 1'b0;
                        m_data_next.written_bytes = '0;
                        m_data_next.unsent_bytes  = unsent_reg;
                        m_data_next.unacked_bytes = unacked_reg;
                        m_data_next.entries_held  = tsbt_pkg::held_t'(count_reg);
                        m_valid_next = 1'b1;
                        state_next   = tsbt_pkg::FSM_IDLE;
                    end
                end else if (bytes_reg >= rem_ack) begin
                    // Pop the head and fetch the next one for the following cycle.
                    bytes_next   = bytes_reg - rem_ack;
                    unacked_next = unacked_reg - rem_ack;
                    ack_off_next = '0;
                    if (send_entry_reg == '0) begin
                        unsent_next   = unsent_reg - rem_send;
                        send_off_next = '0;
                    end else begin
                        send_entry_next = send_entry_reg - CNT_W'(1);
                    end
                    head_next  = slot_of(head_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = head_next;
                end else begin
                    ack_off_next = ack_off_reg + bytes_reg;
                    unacked_next = unacked_reg - bytes_reg;
                    bytes_next   = '0;
                end
            end

            default: begin
                state_next = tsbt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= bytes_reg;
        end
        if (rd_en) begin
            rd_data_reg <= ring[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tsbt_pkg::FSM_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            send_entry_reg <= '0;
            send_off_reg   <= '0;
            ack_off_reg    <= '0;
            unsent_reg     <= '0;
            unacked_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            send_entry_reg <= send_entry_next;
            send_off_reg   <= send_off_next;
            ack_off_reg    <= ack_off_next;
            unsent_reg     <= unsent_next;
            unacked_reg    <= unacked_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        bytes_reg  <= bytes_next;
        m_data_reg <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds the ring depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        send_entry_reg <= count_reg)
        else $error("send pointer lies beyond the queued buffers");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> (unsent_reg == 32'd0 && unacked_reg == 32'd0 &&
                             send_off_reg == 32'd0 && ack_off_reg == 32'd0))
        else $error("empty queue still carries offsets or byte totals");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while an item is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("pending result dropped or changed");

endmodule
